### sv/mp2x2_pkg.sv
// Shared constants and types for the 2x2 stride-2 max pooling block.
`default_nettype none
package mp2x2_pkg;

	localparam int MAX_WIDTH    = 32;
	localparam int MAX_HEIGHT   = 32;
	localparam int MAX_CHANNELS = 64;
	localparam int DATA_WIDTH   = 16;

	localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int SLOT_W      = $clog2(STORE_DEPTH);

	// position counters
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int CHAN_W = $clog2(MAX_CHANNELS);

	// clamped sizes
	localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
	localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
	localparam int CC_W   = $clog2(MAX_CHANNELS + 1);

	// register file
	localparam int WIDTH_REG_W  = 6;
	localparam int HEIGHT_REG_W = 6;
	localparam int CHAN_REG_W   = 7;
	localparam int ADDR_W       = 4;
	localparam int APB_DATA_W   = 32;

	localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET    = WIDTH_REG_W'(24);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET   = HEIGHT_REG_W'(24);
	localparam logic [CHAN_REG_W-1:0]   CHANNELS_RESET = CHAN_REG_W'(20);

	typedef logic signed [DATA_WIDTH-1:0] data_t;

	typedef struct packed {
		logic [DIM_W-1:0]  width;
		logic [HDIM_W-1:0] height;
		logic [CC_W-1:0]   channels;
		logic [DIM_W-1:0]  pair_cols;
		logic [HDIM_W-1:0] pair_rows;
	} dims_t;

	typedef struct packed {
		logic              in_pair;
		logic              odd_col;
		logic              odd_row;
		logic              last_win;
		logic [SLOT_W-1:0] slot;
	} pos_t;

endpackage
`default_nettype wire

### sv/max_pool_2x2_stride2.sv
// Top level: streaming 2x2 stride-2 max pooling over signed feature maps.
//
//   channel   handshake                     payload
//   sample    sample_valid / sample_ready   sample[15:0] signed
//   pooled    pooled_valid / pooled_ready   pooled_value[15:0] signed, frame_end
//   config    psel/penable/pwrite, pready   paddr[3:0], pwdata/prdata[31:0]
//
// One sample word per cycle sustained unless a stalled output fills the read stage.
// Even-row pairs are written to the line store on acceptance; odd-row pairs read it,
// and the result passes through the line store read and then the output register.
// Reset clears counters, the held value and all valid flags; the line store is not cleared.
// A stalled output holds the read stage; samples keep flowing until that stage is full.
`default_nettype none
module max_pool_2x2_stride2 (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             sample_valid,
	output logic                                  sample_ready,
	input  wire mp2x2_pkg::data_t                 sample,
	output logic                                  pooled_valid,
	input  wire logic                             pooled_ready,
	output mp2x2_pkg::data_t                      pooled_value,
	output logic                                  frame_end,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [mp2x2_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [mp2x2_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [mp2x2_pkg::APB_DATA_W-1:0] prdata,
	output logic                                  pready
);
	import mp2x2_pkg::*;

	dims_t dims;
	pos_t  pos;
	logic  accept;
	logic  mem_we;
	logic  mem_re;
	data_t pair_max;
	data_t rd_data;
	data_t win_max;

	data_t held_q;
	logic  valid_s1;
	data_t m_s1;
	logic  fe_s1;
	logic  s1_move;
	logic  out_valid_q;
	data_t out_value_q;
	logic  out_fe_q;

	mp2x2_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.dims    (dims)
	);

	mp2x2_pos u_pos (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.dims    (dims),
		.pos     (pos)
	);

	assign accept   = sample_valid & sample_ready;
	assign pair_max = (held_q > sample) ? held_q : sample;
	assign mem_we   = accept & pos.in_pair & pos.odd_col & ~pos.odd_row;
	assign mem_re   = accept & pos.in_pair & pos.odd_col & pos.odd_row;

	mp2x2_line_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (pos.slot),
		.wdata (pair_max),
		.re    (mem_re),
		.raddr (pos.slot),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (accept && pos.in_pair && !pos.odd_col) begin
			held_q <= sample;
		end
	end

	// read stage: waits on the line store word, drains into the output register
	assign s1_move      = valid_s1 & (~out_valid_q | pooled_ready);
	assign sample_ready = ~valid_s1 | s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (mem_re) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			m_s1  <= pair_max;
			fe_s1 <= pos.last_win;
		end
	end

	assign win_max = (rd_data > m_s1) ? rd_data : m_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (pooled_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_value_q <= win_max;
			out_fe_q    <= fe_s1;
		end
	end

	assign pooled_valid = out_valid_q;
	assign pooled_value = out_value_q;
	assign frame_end    = out_fe_q;

	a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("line store written and read by the same word");

	a_read_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> valid_s1)
		else $error("line store read did not fill the read stage");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_move |=> valid_s1 && $stable(m_s1) && $stable(rd_data))
		else $error("stalled read stage lost its word");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !pooled_ready |-> !sample_ready)
		else $error("sample taken while both stages are full");

endmodule
`default_nettype wire

### sv/mp2x2_cfg.sv
// APB register file for the frame size, with clamping of the sizes.
`default_nettype none
module mp2x2_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [mp2x2_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [mp2x2_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [mp2x2_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	output mp2x2_pkg::dims_t                     dims
);
	import mp2x2_pkg::*;

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [CHAN_REG_W-1:0]   channels_q;
	logic                    wr_en;
	logic [1:0]              reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_RESET;
			height_q   <= HEIGHT_RESET;
			channels_q <= CHANNELS_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_IMAGE_WIDTH:   width_q    <= pwdata[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT:  height_q   <= pwdata[HEIGHT_REG_W-1:0];
				REG_CHANNEL_COUNT: channels_q <= pwdata[CHAN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IMAGE_WIDTH:   prdata = APB_DATA_W'(width_q);
			REG_IMAGE_HEIGHT:  prdata = APB_DATA_W'(height_q);
			REG_CHANNEL_COUNT: prdata = APB_DATA_W'(channels_q);
			default:           prdata = '0;
		endcase
	end

	// width and height below 2 act as 2, a channel count of 0 as 1; above the maximum saturate
	always_comb begin
		if (width_q < 2)
			dims.width = DIM_W'(2);
		else if (width_q > MAX_WIDTH)
			dims.width = DIM_W'(MAX_WIDTH);
		else
			dims.width = DIM_W'(width_q);

		if (height_q < 2)
			dims.height = HDIM_W'(2);
		else if (height_q > MAX_HEIGHT)
			dims.height = HDIM_W'(MAX_HEIGHT);
		else
			dims.height = HDIM_W'(height_q);

		if (channels_q < 1)
			dims.channels = CC_W'(1);
		else if (channels_q > MAX_CHANNELS)
			dims.channels = CC_W'(MAX_CHANNELS);
		else
			dims.channels = CC_W'(channels_q);

		dims.pair_cols = {dims.width[DIM_W-1:1], 1'b0};
		dims.pair_rows = {dims.height[HDIM_W-1:1], 1'b0};
	end

endmodule
`default_nettype wire

### sv/mp2x2_pos.sv
// Column, row and channel counters and the window decode of the current word.
`default_nettype none
module mp2x2_pos (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire mp2x2_pkg::dims_t dims,
	output mp2x2_pkg::pos_t       pos
);
	import mp2x2_pkg::*;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [CHAN_W-1:0] chan_q;
	logic [DIM_W-1:0]  col_inc;
	logic [HDIM_W-1:0] row_inc;
	logic [CC_W-1:0]   chan_inc;
	logic              col_wrap;
	logic              row_wrap;
	logic              chan_wrap;

	assign col_inc   = DIM_W'(col_q) + DIM_W'(1);
	assign row_inc   = HDIM_W'(row_q) + HDIM_W'(1);
	assign chan_inc  = CC_W'(chan_q) + CC_W'(1);
	assign col_wrap  = col_inc >= dims.width;
	assign row_wrap  = row_inc >= dims.height;
	assign chan_wrap = chan_inc >= dims.channels;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			chan_q <= '0;
		end else if (advance) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q  <= '0;
					chan_q <= chan_wrap ? '0 : chan_inc[CHAN_W-1:0];
				end else begin
					row_q <= row_inc[ROW_W-1:0];
				end
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	assign pos.in_pair  = (DIM_W'(col_q) < dims.pair_cols) && (HDIM_W'(row_q) < dims.pair_rows);
	assign pos.odd_col  = col_q[0];
	assign pos.odd_row  = row_q[0];
	assign pos.slot     = col_q[COL_W-1:1];
	assign pos.last_win = (col_inc == dims.pair_cols) && (row_inc == dims.pair_rows)
		&& (chan_inc == dims.channels);

endmodule
`default_nettype wire

### sv/mp2x2_line_mem.sv
// Half-width line store of column-pair maxima, one write and one registered read port.
`default_nettype none
module mp2x2_line_mem (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [mp2x2_pkg::SLOT_W-1:0] waddr,
	input  wire mp2x2_pkg::data_t             wdata,
	input  wire logic                         re,
	input  wire logic [mp2x2_pkg::SLOT_W-1:0] raddr,
	output mp2x2_pkg::data_t                  rdata
);
	import mp2x2_pkg::*;

	data_t mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the streaming 2x2 stride-2 max pooling block.
`timescale 1ns / 1ps
module testbench;
	import mp2x2_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DIRECTED_N    = 24;
	localparam int RANDOM_ITEMS  = 750;
	localparam int SETTLE_CYCLES = 6;
	localparam int LONG_HOLD     = 100;
	localparam int HOLD_SPACING  = 120;
	localparam int MAX_PRINTED   = 40;

	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam data_t DMAX  = 16'sh7fff;
	localparam data_t DMIN  = 16'sh8000;
	localparam data_t DNEG1 = 16'shffff;
	localparam data_t DZERO = 16'sh0000;

	typedef enum int {DATA_FULL, DATA_TIES, DATA_RAILS} data_mode_t;

	typedef struct packed {
		data_t val;
		logic  last;
	} pooled_word_t;

	// one directed sample; typed rows carry their own expected word
	typedef struct packed {
		data_t smp;
		logic  typed;
		logic  emits;
		data_t max_val;
		logic  last;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic sample_valid;
	logic sample_ready;
	data_t sample;
	logic pooled_valid;
	logic pooled_ready;
	data_t pooled_value;
	logic frame_end;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	// predictor state
	logic [WIDTH_REG_W-1:0]  width_reg;
	logic [HEIGHT_REG_W-1:0] height_reg;
	logic [CHAN_REG_W-1:0]   chans_reg;
	data_t line_max [STORE_DEPTH];
	data_t held_val;
	int col_pos;
	int row_pos;
	int chan_pos;

	pooled_word_t pending_words [$];

	int errors;
	int items_fed;
	int words_seen;
	int frame_ends_seen;
	int size_settings;
	int input_stalls;
	int cycle_count;
	int hold_mark;
	bit no_idle;
	bit feeding;

	step_row_t directed_rows [DIRECTED_N] = '{
		'{DMAX, 1'b1, 1'b0, DZERO, 1'b0}, '{DMIN, 1'b1, 1'b0, DZERO, 1'b0},
		'{DMIN, 1'b1, 1'b0, DZERO, 1'b0}, '{DMIN, 1'b1, 1'b1, DMAX, 1'b1},
		'{DMIN, 1'b1, 1'b0, DZERO, 1'b0}, '{DMIN, 1'b1, 1'b0, DZERO, 1'b0},
		'{DMIN, 1'b1, 1'b0, DZERO, 1'b0}, '{DMIN, 1'b1, 1'b1, DMIN, 1'b1},
		'{DMIN, 1'b1, 1'b0, DZERO, 1'b0}, '{DMIN, 1'b1, 1'b0, DZERO, 1'b0},
		'{DMIN, 1'b1, 1'b0, DZERO, 1'b0}, '{DMAX, 1'b1, 1'b1, DMAX, 1'b1},
		'{DNEG1, 1'b1, 1'b0, DZERO, 1'b0}, '{DNEG1, 1'b1, 1'b0, DZERO, 1'b0},
		'{DNEG1, 1'b1, 1'b0, DZERO, 1'b0}, '{DNEG1, 1'b1, 1'b1, DNEG1, 1'b1},
		'{DZERO, 1'b0, 1'b0, DZERO, 1'b0}, '{DNEG1, 1'b0, 1'b0, DZERO, 1'b0},
		'{DMAX, 1'b0, 1'b0, DZERO, 1'b0}, '{DMIN, 1'b0, 1'b0, DZERO, 1'b0},
		'{16'sd5, 1'b0, 1'b0, DZERO, 1'b0}, '{-16'sd7, 1'b0, 1'b0, DZERO, 1'b0},
		'{16'sd100, 1'b0, 1'b0, DZERO, 1'b0}, '{16'sd99, 1'b0, 1'b0, DZERO, 1'b0}
	};

	max_pool_2x2_stride2 u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.pooled_valid (pooled_valid),
		.pooled_ready (pooled_ready),
		.pooled_value (pooled_value),
		.frame_end    (frame_end),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (errors < MAX_PRINTED)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int clamp_int(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Advances the position counters by one word; returns 1 when a window closes.
	function automatic bit predict_pool(input data_t s, output data_t win_max, output logic last);
		int w;
		int h;
		int cc;
		int pair_cols;
		int pair_rows;
		data_t pair_max;
		bit emits;
		w = clamp_int(int'(width_reg), 2, MAX_WIDTH);
		h = clamp_int(int'(height_reg), 2, MAX_HEIGHT);
		cc = clamp_int(int'(chans_reg), 1, MAX_CHANNELS);
		pair_cols = w & ~1;
		pair_rows = h & ~1;
		emits = 1'b0;
		win_max = DZERO;
		last = 1'b0;
		if (col_pos < pair_cols && row_pos < pair_rows) begin
			if (col_pos % 2 == 0) begin
				held_val = s;
			end else begin
				pair_max = (s > held_val) ? s : held_val;
				if (row_pos % 2 == 0) begin
					line_max[col_pos / 2] = pair_max;
				end else begin
					win_max = (pair_max > line_max[col_pos / 2]) ? pair_max : line_max[col_pos / 2];
					last = (col_pos == pair_cols - 1 && row_pos == pair_rows - 1 && chan_pos == cc - 1);
					emits = 1'b1;
				end
			end
		end
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			if (row_pos + 1 >= h) begin
				row_pos = 0;
				chan_pos = (chan_pos + 1 >= cc) ? 0 : chan_pos + 1;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
		return emits;
	endfunction

	function automatic data_t pick_sample(input data_mode_t mode);
		case (mode)
			DATA_TIES: return data_t'(int'($urandom_range(0, 6)) - 3);
			DATA_RAILS: begin
				case ($urandom_range(0, 3))
					0: return DMIN;
					1: return DMAX;
					2: return DNEG1;
					default: return DZERO;
				endcase
			end
			default: return data_t'($urandom());
		endcase
	endfunction

	// mostly small sizes, now and then below the floor or at or above the ceiling
	function automatic int pick_dim();
		case ($urandom_range(0, 15))
			0: return $urandom_range(0, 1);
			1: return $urandom_range(32, 63);
			default: return $urandom_range(2, 9);
		endcase
	endfunction

	task automatic apb_cycle(input logic [1:0] idx, input bit wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int value);
		logic [31:0] keep;
		logic [31:0] wdata;
		logic [31:0] rdata;
		keep = (idx == REG_CHANNEL_COUNT) ? 32'h7f : 32'h3f;
		wdata = value;
		// upper bits are don't-care for the register
		if ($urandom_range(0, 3) == 0)
			wdata = wdata | ($urandom() & ~keep);
		apb_cycle(idx, 1'b1, wdata, rdata);
		case (idx)
			REG_IMAGE_WIDTH: width_reg = wdata[WIDTH_REG_W-1:0];
			REG_IMAGE_HEIGHT: height_reg = wdata[HEIGHT_REG_W-1:0];
			REG_CHANNEL_COUNT: chans_reg = wdata[CHAN_REG_W-1:0];
			default: ;
		endcase
		if (idx != REG_UNUSED) begin
			apb_cycle(idx, 1'b0, 32'h0, rdata);
			if (rdata !== (wdata & keep))
				report_mismatch($sformatf("reg %0d reads 0x%0h, wrote 0x%0h", idx, rdata, wdata));
		end
	endtask

	task automatic set_sizes(input int w, input int h, input int cc);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_CHANNEL_COUNT, cc);
		size_settings++;
	endtask

	task automatic send_word(input data_t s);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (!sample_ready);
	endtask

	task automatic feed_sample(input data_t s, input bit use_typed, input bit typed_emits,
			input pooled_word_t typed_word);
		data_t win_max;
		logic last;
		bit emits;
		send_word(s);
		emits = predict_pool(s, win_max, last);
		if (use_typed) begin
			if (typed_emits)
				pending_words.push_back(typed_word);
		end else if (emits) begin
			pending_words.push_back(pooled_word_t'{win_max, last});
		end
		items_fed++;
	endtask

	// Block is idle once every window is out and the last no-result word has passed through.
	task automatic drain();
		sample_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Feeds whole channels so that phases end on a channel boundary.
	task automatic run_phase(input int n_ch, input data_mode_t mode);
		int per_ch;
		per_ch = clamp_int(int'(width_reg), 2, MAX_WIDTH) *
			clamp_int(int'(height_reg), 2, MAX_HEIGHT);
		no_idle = ($urandom_range(0, 4) == 0);
		feeding = 1'b1;
		for (int i = 0; i < n_ch * per_ch; i++)
			feed_sample(pick_sample(mode), 1'b0, 1'b0, '0);
		feeding = 1'b0;
		drain();
	endtask

	// result side
	initial begin
		int idle_n;
		pooled_word_t want;
		pooled_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (feeding && words_seen >= hold_mark) begin
				// long hold so the pipeline backs up into the input
				idle_n = LONG_HOLD;
				hold_mark += HOLD_SPACING;
			end else begin
				idle_n = no_idle ? 0 : $urandom_range(0, 4);
			end
			if (idle_n > 0) begin
				pooled_ready <= 1'b0;
				repeat (idle_n) @(posedge clk);
			end
			pooled_ready <= 1'b1;
			do @(posedge clk); while (!pooled_valid);
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("word %0d arrived with nothing expected", pooled_value));
			end else begin
				want = pending_words.pop_front();
				if (pooled_value !== want.val)
					report_mismatch($sformatf("pooled_value %0d, expected %0d",
						pooled_value, want.val));
				if (frame_end !== want.last)
					report_mismatch($sformatf("frame_end %0b, expected %0b (value %0d)",
						frame_end, want.last, want.val));
			end
			words_seen++;
			if (frame_end)
				frame_ends_seen++;
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		input_stalls = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
			if (sample_valid && !sample_ready)
				input_stalls++;
		end
		$display("Timed out after %0d cycles", cycle_count);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int w;
		int h;
		int cc;
		data_mode_t mode;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = DZERO;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		items_fed = 0;
		words_seen = 0;
		frame_ends_seen = 0;
		size_settings = 0;
		hold_mark = 20;
		no_idle = 1'b0;
		feeding = 1'b0;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		chans_reg = CHANNELS_RESET;
		foreach (line_max[i])
			line_max[i] = DZERO;
		held_val = DZERO;
		col_pos = 0;
		row_pos = 0;
		chan_pos = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one 2x2 window per frame, rails and ties
		set_sizes(2, 2, 1);
		foreach (directed_rows[i])
			feed_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].emits,
				pooled_word_t'{directed_rows[i].max_val, directed_rows[i].last});
		drain();

		// size extremes: clamping at both ends, odd trailing row, full channel count
		set_sizes(32, 2, 1);
		run_phase(1, DATA_FULL);
		set_sizes(63, 3, 1);
		run_phase(1, DATA_FULL);
		set_sizes(1, 40, 1);
		run_phase(1, DATA_TIES);
		set_sizes(0, 0, 0);
		run_phase(2, DATA_RAILS);
		set_sizes(2, 2, 127);
		write_reg(REG_UNUSED, $urandom());
		run_phase(64, DATA_FULL);

		while (items_fed < DIRECTED_N + RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				w = pick_dim();
				h = pick_dim();
				if (clamp_int(w, 2, MAX_WIDTH) * clamp_int(h, 2, MAX_HEIGHT) > 96)
					h = $urandom_range(2, 3);
				case ($urandom_range(0, 15))
					0: cc = 0;
					1: cc = $urandom_range(64, 127);
					default: cc = $urandom_range(1, 4);
				endcase
				set_sizes(w, h, cc);
			end
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_UNUSED, $urandom());
			case ($urandom_range(0, 9))
				0, 1: mode = DATA_TIES;
				2: mode = DATA_RAILS;
				default: mode = DATA_FULL;
			endcase
			run_phase($urandom_range(1, 3), mode);
		end
		drain();

		$display("Fed %0d samples under %0d size settings in %0d cycles (%0d input stall cycles).",
			items_fed, size_settings, cycle_count, input_stalls);
		$display("Checked %0d pooled words, %0d of them frame ends; %0d mismatches.",
			words_seen, frame_ends_seen, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
